/* design/ltws_pkg.sv */
// shared constants, types and helpers for the text window scroller
package ltws_pkg;

  localparam int MAX_TEXT = 64;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int CNT_W    = $clog2(MAX_TEXT + 1);
  localparam int WIN_W    = 6;
  localparam int STYLE_W  = 2;
  localparam int REG_IDX_W = 1;
  localparam int CFG_W    = 6;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [STYLE_W-1:0] STYLE_FIXED     = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_PING_PONG = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_ROTATE    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_STYLE  = 1'd1;

  localparam logic [WIN_W-1:0]   WIN_RESET   = 6'd16;
  localparam logic [STYLE_W-1:0] STYLE_RESET = STYLE_PING_PONG;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_CMP,
    ST_PAD,
    ST_LD_FIN,
    ST_EMIT
  } state_e;

  // frame start position, character count and the updated scroll state
  typedef struct packed {
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] offset;
    logic             fwd;
  } plan_t;

  // a window length of zero acts as one
  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [CNT_W-1:0] r;
    r = (w == '0) ? CNT_W'(1) : CNT_W'(w);
    return r;
  endfunction

endpackage

/* design/ltws_text_ram.sv */
// text store: single write port, one registered read port
module ltws_text_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ltws_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [ltws_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  import ltws_pkg::*;

  logic [7:0] mem [MAX_TEXT];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ltws_window_calc.sv */
// per-frame window placement for the three scroll styles
module ltws_window_calc (
  input  logic [ltws_pkg::STYLE_W-1:0] style_i,
  input  logic [ltws_pkg::WIN_W-1:0]   win_len_i,
  input  logic [ltws_pkg::CNT_W-1:0]   size_i,
  input  logic [ltws_pkg::CNT_W-1:0]   offset_i,
  input  logic                         fwd_i,
  output ltws_pkg::plan_t              plan_o
);
  import ltws_pkg::*;

  logic [CNT_W-1:0] win;
  logic [CNT_W-1:0] max_off;
  logic [CNT_W-1:0] clamp_off;
  logic [CNT_W-1:0] pp_off;
  logic             pp_fwd;
  logic [CNT_W-1:0] pp_rest;
  logic [CNT_W-1:0] rot_off;
  logic [CNT_W-1:0] rot_inc;

  always_comb begin
    win       = eff_window(win_len_i);
    max_off   = (size_i > win) ? size_i - win : '0;
    clamp_off = (offset_i > max_off) ? max_off : offset_i;

    // bounce: step once before the frame, turning at either end
    pp_fwd = fwd_i;
    pp_off = clamp_off;
    if (fwd_i) begin
      if (clamp_off < max_off) begin
        pp_off = clamp_off + 1'b1;
      end else begin
        pp_fwd = 1'b0;
        if (clamp_off != '0) pp_off = clamp_off - 1'b1;
      end
    end else begin
      if (clamp_off != '0) begin
        pp_off = clamp_off - 1'b1;
      end else begin
        pp_fwd = 1'b1;
        if (clamp_off < max_off) pp_off = clamp_off + 1'b1;
      end
    end
    pp_rest = size_i - pp_off;

    rot_off = (offset_i >= size_i) ? '0 : offset_i;
    rot_inc = rot_off + 1'b1;

    case (style_i)
      STYLE_PING_PONG: begin
        plan_o.start  = pp_off;
        plan_o.count  = (pp_rest < win) ? pp_rest : win;
        plan_o.offset = pp_off;
        plan_o.fwd    = pp_fwd;
      end
      STYLE_ROTATE: begin
        plan_o.start  = rot_off;
        plan_o.count  = win;
        plan_o.offset = (rot_inc >= size_i) ? '0 : rot_inc;
        plan_o.fwd    = fwd_i;
      end
      default: begin
        plan_o.start  = '0;
        plan_o.count  = size_i;
        plan_o.offset = offset_i;
        plan_o.fwd    = fwd_i;
      end
    endcase
  end

endmodule

/* design/lcd_text_window_scroller.sv */
// a load character is accepted, then compared with and written to one store entry; the last
// character then writes each padding space it needs and passes through a closing state
// a tick is accepted, then the emit state puts its first character in the output register once
// the output can take it, then one character per cycle while the output is taken; input stays
// stalled until the frame's last character is loaded; the single read port sets this pace
// reset: window 16, ping-pong style, empty text; store contents stay undefined, no clear pass
module lcd_text_window_scroller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ltws_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [ltws_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [7:0]                     char_in_i,
  input  logic                           char_is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     char_out_o,
  output logic                           frame_end_o
);
  import ltws_pkg::*;

  state_e state_q, state_d;

  logic [WIN_W-1:0]   win_len_q;
  logic [STYLE_W-1:0] style_q;
  logic [CNT_W-1:0]   size_q, size_d;
  logic [CNT_W-1:0]   offset_q, offset_d;
  logic               fwd_q, fwd_d;
  logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
  logic               differs_q, differs_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   emit_cnt_q, emit_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               out_end_q, out_end_d;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;

  plan_t              plan;
  logic [CNT_W-1:0]   win_eff;
  logic [CNT_W:0]     win_plus;
  logic [CNT_W-1:0]   pad_target;
  logic               scrolling;
  logic               load_full;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   ld_next;
  logic [CNT_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   pos_next;
  logic               take;

  ltws_text_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ltws_window_calc u_calc (
    .style_i   (style_q),
    .win_len_i (win_len_q),
    .size_i    (size_q),
    .offset_i  (offset_q),
    .fwd_i     (fwd_q),
    .plan_o    (plan)
  );

  always_comb begin
    win_eff    = eff_window(win_len_q);
    win_plus   = {1'b0, win_eff} + 1'b1;
    pad_target = (win_plus > (CNT_W + 1)'(MAX_TEXT)) ? CNT_W'(MAX_TEXT)
                                                      : win_plus[CNT_W-1:0];
    scrolling  = (style_q == STYLE_PING_PONG) || (style_q == STYLE_ROTATE);
    load_full  = load_cnt_q >= CNT_W'(MAX_TEXT);
    cnt_inc    = load_cnt_q + 1'b1;
    ld_next    = load_full ? load_cnt_q : cnt_inc;
    pos_inc    = pos_q + 1'b1;
    pos_next   = (pos_inc >= size_q) ? '0 : pos_inc;
    take       = !out_valid_q || !out_stall_i;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) state_d = ST_LD_CMP;
          else if (size_q != '0) state_d = ST_EMIT;
        end
      end
      ST_LD_CMP: begin
        if (last_q) begin
          state_d = (scrolling && ld_next < win_eff) ? ST_PAD : ST_LD_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (cnt_inc >= pad_target) state_d = ST_LD_FIN;
      end
      ST_LD_FIN: state_d = ST_IDLE;
      ST_EMIT: begin
        if (take && emit_cnt_q == CNT_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    size_d      = size_q;
    offset_d    = offset_q;
    fwd_d       = fwd_q;
    load_cnt_d  = load_cnt_q;
    differs_d   = differs_q;
    char_d      = char_q;
    last_d      = last_q;
    pos_d       = pos_q;
    emit_cnt_d  = emit_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_end_d   = out_end_q;
    mem_we      = 1'b0;
    mem_waddr   = load_cnt_q[ADDR_W-1:0];
    mem_wdata   = char_q;
    mem_raddr   = load_cnt_q[ADDR_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (mode_i) mem_raddr = plan.start[ADDR_W-1:0];
        if (in_valid_i) begin
          char_d = char_in_i;
          last_d = char_is_last_i;
          if (mode_i && size_q != '0) begin
            pos_d      = plan.start;
            emit_cnt_d = plan.count;
            offset_d   = plan.offset;
            fwd_d      = plan.fwd;
          end
        end
      end
      ST_LD_CMP: begin
        mem_raddr = ld_next[ADDR_W-1:0];
        if (!load_full) begin
          mem_we     = 1'b1;
          differs_d  = differs_q || (load_cnt_q >= size_q) || (mem_rdata != char_q);
          load_cnt_d = cnt_inc;
        end
      end
      ST_PAD: begin
        mem_we     = 1'b1;
        mem_wdata  = SPACE_CHAR;
        mem_raddr  = cnt_inc[ADDR_W-1:0];
        differs_d  = differs_q || (load_cnt_q >= size_q) || (mem_rdata != SPACE_CHAR);
        load_cnt_d = cnt_inc;
      end
      ST_LD_FIN: begin
        size_d     = load_cnt_q;
        if (differs_q || load_cnt_q != size_q) begin
          offset_d = '0;
          fwd_d    = 1'b1;
        end
        load_cnt_d = '0;
        differs_d  = 1'b0;
      end
      ST_EMIT: begin
        // keep the read one position ahead so a character follows every cycle while the output is taken
        mem_raddr = take ? pos_next[ADDR_W-1:0] : pos_q[ADDR_W-1:0];
        if (take) begin
          out_valid_d = 1'b1;
          out_char_d  = mem_rdata;
          out_end_d   = (emit_cnt_q == CNT_W'(1));
          pos_d       = pos_next;
          emit_cnt_d  = emit_cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= WIN_RESET;
      style_q     <= STYLE_RESET;
      size_q      <= '0;
      offset_q    <= '0;
      fwd_q       <= 1'b1;
      load_cnt_q  <= '0;
      differs_q   <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      offset_q    <= offset_d;
      fwd_q       <= fwd_d;
      load_cnt_q  <= load_cnt_d;
      differs_q   <= differs_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WINDOW_LENGTH: win_len_q <= cfg_wdata_i[WIN_W-1:0];
          REG_SCROLL_STYLE:  style_q   <= cfg_wdata_i[STYLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    last_q     <= last_d;
    pos_q      <= pos_d;
    out_char_q <= out_char_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign frame_end_o = out_end_q;

  a_tick_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && mode_i && size_q != '0) |=> (state_q == ST_EMIT))
    else $error("accepted tick did not start a frame");

  a_emit_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_cnt_q != '0))
    else $error("frame emission with no characters left");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CNT_W'(MAX_TEXT))
    else $error("text size beyond store depth");

  a_pad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |-> (load_cnt_q < pad_target))
    else $error("padding past its target");

endmodule

/* test/tb_lcd_text_window_scroller.sv */
// testbench for the text window scroller: directed and random transactions against a frame predictor
module tb_lcd_text_window_scroller;
  timeunit 1ns;
  timeprecision 1ps;

  import ltws_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  typedef logic [7:0] char_q_t[$];

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index_i    = REG_WINDOW_LENGTH;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i         = MODE_LOAD;
  logic [7:0]           char_in_i      = '0;
  logic                 char_is_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [7:0]           char_out_o;
  logic                 frame_end_o;

  lcd_text_window_scroller DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .char_in_i      (char_in_i),
    .char_is_last_i (char_is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_out_o     (char_out_o),
    .frame_end_o    (frame_end_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the scroller state
  logic [7:0]         text_mem [MAX_TEXT];
  int unsigned        shown_size;
  int unsigned        view_offset;
  bit                 heading_fwd;
  int unsigned        load_pos;
  bit                 text_changed;
  logic [WIN_W-1:0]   window_reg;
  logic [STYLE_W-1:0] style_reg;

  frame_char_t expected_chars[$];
  char_q_t     last_text;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_request;

  function automatic void save_char(int unsigned pos, logic [7:0] c);
    if (pos >= MAX_TEXT) return;
    if (pos >= shown_size || text_mem[pos] != c) text_changed = 1'b1;
    text_mem[pos] = c;
  endfunction

  function automatic void push_frame_char(logic [7:0] c, bit last);
    frame_char_t fc;
    fc.ch = c;
    fc.last = last;
    expected_chars.push_back(fc);
  endfunction

  function automatic void predict_transaction(logic m, logic [7:0] c, logic l);
    int unsigned w, fill_to, sz, top, stop, pos, k;
    w = (window_reg == '0) ? 1 : int'(window_reg);
    if (m == MODE_LOAD) begin
      if (load_pos < MAX_TEXT) begin
        save_char(load_pos, c);
        load_pos++;
      end
      if (l) begin
        sz = load_pos;
        if ((style_reg == STYLE_PING_PONG || style_reg == STYLE_ROTATE) && sz < w) begin
          fill_to = (w + 1 > MAX_TEXT) ? MAX_TEXT : w + 1;
          while (sz < fill_to) begin
            save_char(sz, SPACE_CHAR);
            sz++;
          end
        end
        if (sz != shown_size) text_changed = 1'b1;
        shown_size = sz;
        if (text_changed) begin
          view_offset = 0;
          heading_fwd = 1'b1;
        end
        load_pos = 0;
        text_changed = 1'b0;
      end
      return;
    end
    if (shown_size == 0) return;
    case (style_reg)
      STYLE_PING_PONG: begin
        top = (shown_size > w) ? shown_size - w : 0;
        if (view_offset > top) view_offset = top;
        if (heading_fwd) begin
          if (view_offset < top) view_offset++;
          else begin
            heading_fwd = 1'b0;
            if (view_offset > 0) view_offset--;
          end
        end else begin
          if (view_offset > 0) view_offset--;
          else begin
            heading_fwd = 1'b1;
            if (view_offset < top) view_offset++;
          end
        end
        stop = view_offset + w;
        if (stop > shown_size) stop = shown_size;
        for (pos = view_offset; pos < stop; pos++) begin
          push_frame_char(text_mem[pos % MAX_TEXT], pos + 1 == stop);
        end
      end
      STYLE_ROTATE: begin
        if (view_offset >= shown_size) view_offset = 0;
        pos = view_offset;
        for (k = 0; k < w; k++) begin
          push_frame_char(text_mem[pos % MAX_TEXT], k + 1 == w);
          pos++;
          if (pos >= shown_size) pos = 0;
        end
        view_offset++;
        if (view_offset >= shown_size) view_offset = 0;
      end
      default: begin
        for (k = 0; k < shown_size && k < MAX_TEXT; k++) begin
          push_frame_char(text_mem[k], k + 1 == shown_size);
        end
      end
    endcase
  endfunction

  // result checker
  frame_char_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        $error("unexpected transaction: char_out %02h frame_end %0b", char_out_o, frame_end_o);
      end else begin
        want = expected_chars.pop_front();
        if (char_out_o !== want.ch) begin
          error_count++;
          $error("char_out mismatch: expected %02h actual %02h", want.ch, char_out_o);
        end
        if (frame_end_o !== want.last) begin
          error_count++;
          $error("frame_end mismatch: expected %0b actual %0b", want.last, frame_end_o);
        end
      end
    end
  end

  // output back-pressure: short random bursts, or one long hold on request
  always begin : drive_out_stall
    int unsigned held;
    @(posedge clk_i);
    if (hold_request) begin
      hold_request = 1'b0;
      out_stall_i <= 1'b1;
      held = 0;
      while (held < LONG_HOLD) begin
        @(posedge clk_i);
        held++;
      end
      out_stall_i <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_lcd_text_window_scroller failed");
    $finish;
  end

  task automatic send_item(input logic m, input logic [7:0] c, input logic l);
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    char_in_i      <= c;
    char_is_last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_transaction(m, c, l);
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // loads cause no result, so give the padding pass time to finish as well
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_display(input int unsigned win, input int unsigned sty);
    logic [CFG_W-1:0] data;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WINDOW_LENGTH;
    cfg_wdata_i <= CFG_W'(win);
    @(posedge clk_i);
    window_reg = WIN_W'(win);
    // upper data bits are junk for the style register
    data = CFG_W'($urandom);
    data[STYLE_W-1:0] = STYLE_W'(sty);
    cfg_index_i <= REG_SCROLL_STYLE;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    style_reg = STYLE_W'(sty);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_text(input char_q_t text);
    for (int i = 0; i < text.size(); i++) begin
      send_item(MODE_LOAD, text[i], i == text.size() - 1);
    end
    last_text = text;
  endtask

  task automatic tick(input int unsigned n);
    repeat (n) send_item(MODE_TICK, 8'($urandom), 1'($urandom));
  endtask

  function automatic char_q_t random_text(int unsigned len);
    char_q_t t;
    repeat (len) t.push_back(8'($urandom));
    return t;
  endfunction

  task automatic test_reset_scrolling();
    tick(1);  // nothing loaded yet
    load_text('{8'h00, 8'hFF, 8'h41});
    tick(3);
    load_text('{8'h00, 8'hFF, 8'h41});  // same text keeps offset and direction
    tick(1);
    // tick while a new text is half loaded
    send_item(MODE_LOAD, 8'h42, 1'b0);
    send_item(MODE_LOAD, 8'h43, 1'b0);
    tick(1);
    send_item(MODE_LOAD, 8'h44, 1'b1);
    tick(1);
  endtask

  task automatic test_style_extremes();
    set_display(0, STYLE_FIXED);
    tick(1);
    set_display(5, 3);
    tick(1);
    set_display(0, STYLE_ROTATE);
    tick(2);
    // short unpadded text, then a window wider than it
    set_display(10, STYLE_FIXED);
    load_text('{8'h61, 8'h62, 8'h63});
    set_display(10, STYLE_ROTATE);
    tick(2);
    set_display(16, STYLE_PING_PONG);
    tick(1);
    // padding stops at the store size
    set_display(63, STYLE_PING_PONG);
    load_text('{8'h7E, 8'h01});
    tick(1);
  endtask

  task automatic test_overlong_text();
    char_q_t t;
    set_display(8, STYLE_ROTATE);
    t = random_text(MAX_TEXT + 6);
    load_text(t);
    tick(3);
    // the dropped tail differs but the kept text does not
    for (int i = MAX_TEXT; i < t.size(); i++) t[i] = ~t[i];
    load_text(t);
    tick(1);
  endtask

  task automatic test_random_rounds();
    int unsigned win, sty, budget, pick, len;
    bit          hold_done, drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    for (int r = 0; r < 6; r++) begin
      case (r)
        0: begin win = 1; sty = STYLE_ROTATE; end
        1: begin win = 40; sty = STYLE_PING_PONG; end
        2: begin win = $urandom_range(1, 40); sty = STYLE_FIXED; end
        3: begin win = 63; sty = STYLE_ROTATE; end
        default: begin win = $urandom_range(0, 63); sty = $urandom_range(0, 3); end
      endcase
      if (r == 5) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      set_display(win, sty);
      budget = items_sent + 18;
      while (items_sent < budget) begin
        if (r == 1 && !hold_done) begin
          // output held off while ticks keep coming
          hold_done = 1'b1;
          hold_request = 1'b1;
          tick(8);
        end
        if (r == 2 && !drain_done && items_sent + 9 >= budget) begin
          drain_done = 1'b1;
          wait_drained();
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if ($urandom_range(0, 19) == 0 && last_text.size() != 0) load_text(last_text);
          else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            load_text(random_text(len));
          end
          tick($urandom_range(1, 5));
        end else if (pick < 85) begin
          tick($urandom_range(1, 3));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom), 8'($urandom), 1'($urandom));
          end
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_TEXT; i++) text_mem[i] = '0;
    shown_size   = 0;
    view_offset  = 0;
    heading_fwd  = 1'b1;
    load_pos     = 0;
    text_changed = 1'b0;
    window_reg   = WIN_RESET;
    style_reg    = STYLE_RESET;
    error_count  = 0;
    items_sent   = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_scrolling();
    test_style_extremes();
    test_overlong_text();
    test_random_rounds();

    settle();
    if (error_count == 0) begin
      $display("tb_lcd_text_window_scroller passed");
    end else begin
      $display("tb_lcd_text_window_scroller failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ltws_pkg.sv
design/ltws_text_ram.sv
design/ltws_window_calc.sv
design/lcd_text_window_scroller.sv
test/tb_lcd_text_window_scroller.sv
